FILE: rtl/pfvc_pkg.sv
// ----------------------------------------------------------------------------
// pfvc_pkg
// Types, register codes, constants and helpers shared by the potential
// field velocity command pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pfvc_pkg;

   localparam int ROTATE_STAGES = 16;
   localparam int ATAN_COUNT    = 24;
   localparam int CORDIC_STEPS  = (ROTATE_STAGES < ATAN_COUNT) ? ROTATE_STAGES : ATAN_COUNT;

   // cordic datapath: input, scaled working width and rounded output
   localparam int CORDIC_IN_W   = 36;
   localparam int PRE_SHIFT     = 8;
   localparam int CORDIC_W      = CORDIC_IN_W + PRE_SHIFT;
   localparam int PROD_W        = CORDIC_W + 17;
   localparam int CORDIC_OUT_W  = 36;
   // pre-rotation, steps, multiply, round
   localparam int CORDIC_LATENCY = CORDIC_STEPS + 3;

   localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;

   // bearing to angle: 2^32/360 = 11930464 + 256/360
   localparam logic [8:0]  BRG_WRAP   = 9'd360;
   localparam logic [23:0] BRG_STEP   = 24'd11930464;
   localparam logic [16:0] BRG_HALF   = 17'd180;
   localparam logic [16:0] BRG_RECIP  = 17'd93207;
   localparam int          BRG_RSHIFT = 25;

   localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam logic [2:0] CSR_OUTER_RADIUS  = 3'd0;
   localparam logic [2:0] CSR_INNER_RADIUS  = 3'd1;
   localparam logic [2:0] CSR_TRACK_GAIN    = 3'd2;
   localparam logic [2:0] CSR_TRACK_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_OUTER_SLOPE   = 3'd4;
   localparam logic [2:0] CSR_INNER_SLOPE   = 3'd5;
   localparam logic [2:0] CSR_REPEL_LIMIT   = 3'd6;
   localparam logic [2:0] CSR_COMMAND_LIMIT = 3'd7;

   typedef struct packed {
      logic signed [15:0] here_east;
      logic signed [15:0] here_north;
      logic signed [15:0] goal_east;
      logic signed [15:0] goal_north;
      logic        [15:0] obstacle_distance;
      logic        [8:0]  obstacle_bearing;
      logic        [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] vel_east;
      logic signed [15:0] vel_north;
      logic               avoid_active;
   } rsp_type;

   function automatic logic signed [15:0] clip_limit(input logic signed [39:0] v,
                                                     input logic [14:0] lim);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = signed'({25'd0, lim});
      lo = -hi;
      if (v > hi) begin
         return hi[15:0];
      end else if (v < lo) begin
         return lo[15:0];
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7fff;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pfvc_cordic.sv
// ----------------------------------------------------------------------------
// pfvc_cordic
// Pipelined rotation of a vector by an angle of 2^32 per turn: quadrant
// fold, one register per micro-rotation, gain correction and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvc_cordic
   import pfvc_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic signed [CORDIC_IN_W-1:0]  in_x,
   input  wire logic signed [CORDIC_IN_W-1:0]  in_y,
   input  wire logic        [31:0]             in_angle,
   output logic                                out_valid,
   output logic signed [CORDIC_OUT_W-1:0]      out_x,
   output logic signed [CORDIC_OUT_W-1:0]      out_y
);

   logic                       v_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] a_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] b_ff [CORDIC_STEPS+1];
   logic signed [31:0]         z_ff [CORDIC_STEPS+1];

   logic                       flip;
   logic [31:0]                turn_in;
   logic [31:0]                angle_in;
   logic signed [CORDIC_W-1:0] ax_in;
   logic signed [CORDIC_W-1:0] by_in;

   // fold angles in [90,270) degrees by negating the vector
   always_comb begin
      turn_in  = in_angle + 32'h4000_0000;
      flip     = turn_in[31];
      angle_in = flip ? (in_angle + 32'h8000_0000) : in_angle;
      ax_in    = CORDIC_W'(in_x) <<< PRE_SHIFT;
      by_in    = CORDIC_W'(in_y) <<< PRE_SHIFT;
      if (flip) begin
         ax_in = -ax_in;
         by_in = -by_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         a_ff[0] <= ax_in;
         b_ff[0] <= by_in;
         z_ff[0] <= signed'(angle_in);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      logic signed [31:0]         step;
      assign dx   = b_ff[i] >>> i;
      assign dy   = a_ff[i] >>> i;
      assign step = signed'(ATAN_TURN[i]);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
            if (!z_ff[i][31]) begin
               a_ff[i+1] <= a_ff[i] - dx;
               b_ff[i+1] <= b_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end else begin
               a_ff[i+1] <= a_ff[i] + dx;
               b_ff[i+1] <= b_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end
         end
      end
   end

   logic                     mv_ff;
   logic signed [PROD_W-1:0] mx_ff;
   logic signed [PROD_W-1:0] my_ff;
   logic signed [PROD_W-1:0] rx_in;
   logic signed [PROD_W-1:0] ry_in;
   logic                     ov_ff;
   logic signed [CORDIC_OUT_W-1:0] ox_ff;
   logic signed [CORDIC_OUT_W-1:0] oy_ff;

   assign rx_in = mx_ff + (PROD_W'(1) <<< 23);
   assign ry_in = my_ff + (PROD_W'(1) <<< 23);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         mv_ff <= v_ff[CORDIC_STEPS];
         mx_ff <= PROD_W'(a_ff[CORDIC_STEPS]) * PROD_W'(signed'(INV_GAIN_Q16));
         my_ff <= PROD_W'(b_ff[CORDIC_STEPS]) * PROD_W'(signed'(INV_GAIN_Q16));
         ov_ff <= mv_ff;
         ox_ff <= rx_in[CORDIC_OUT_W+23:24];
         oy_ff <= ry_in[CORDIC_OUT_W+23:24];
      end
   end

   assign out_valid = ov_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;

endmodule

`default_nettype wire

FILE: rtl/potential_field_velocity_command.sv
// Pipeline: stages 1 to 3, the repulsion rotation, stages 4 and 5, the heading rotation
// and the output register lie in series between an accepted request and its response.
// Throughput: one transaction per cycle; a stalled response freezes the whole pipeline.
// Reset: synchronous, active high; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// potential_field_velocity_command
// Tracking velocity plus clipped obstacle repulsion, rotated by heading.
// ----------------------------------------------------------------------------
`default_nettype none

module potential_field_velocity_command
   import pfvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0] outer_radius_ff, inner_radius_ff, track_gain_ff;
   logic [15:0] outer_slope_ff, inner_slope_ff;
   logic [14:0] track_limit_ff, repel_limit_ff, command_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_radius_ff  <= 16'd2000;
         inner_radius_ff  <= 16'd1000;
         track_gain_ff    <= 16'd128;
         track_limit_ff   <= 15'd500;
         outer_slope_ff   <= 16'd0;
         inner_slope_ff   <= 16'd0;
         repel_limit_ff   <= 15'd0;
         command_limit_ff <= 15'd0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_OUTER_RADIUS:  outer_radius_ff  <= csr_wdata;
            CSR_INNER_RADIUS:  inner_radius_ff  <= csr_wdata;
            CSR_TRACK_GAIN:    track_gain_ff    <= csr_wdata;
            CSR_TRACK_LIMIT:   track_limit_ff   <= csr_wdata[14:0];
            CSR_OUTER_SLOPE:   outer_slope_ff   <= csr_wdata;
            CSR_INNER_SLOPE:   inner_slope_ff   <= csr_wdata;
            CSR_REPEL_LIMIT:   repel_limit_ff   <= csr_wdata[14:0];
            CSR_COMMAND_LIMIT: command_limit_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: differences, branch select, bearing wrap
   logic               v1_ff;
   logic signed [16:0] ex1_ff, ey1_ff, ro_d1_ff, ri_d1_ff, ro_ri1_ff;
   logic               act1_ff, steep1_ff;
   logic [8:0]         brg1_ff;
   logic [15:0]        head1_ff;
   logic [8:0]         brg_in;

   assign brg_in = (req_data.obstacle_bearing >= BRG_WRAP) ?
                   (req_data.obstacle_bearing - BRG_WRAP) : req_data.obstacle_bearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff     <= req_valid;
         ex1_ff    <= 17'(req_data.goal_east) - 17'(req_data.here_east);
         ey1_ff    <= 17'(req_data.goal_north) - 17'(req_data.here_north);
         ro_d1_ff  <= signed'({1'b0, outer_radius_ff}) - signed'({1'b0, req_data.obstacle_distance});
         ri_d1_ff  <= signed'({1'b0, inner_radius_ff}) - signed'({1'b0, req_data.obstacle_distance});
         ro_ri1_ff <= signed'({1'b0, outer_radius_ff}) - signed'({1'b0, inner_radius_ff});
         act1_ff   <= req_data.obstacle_distance < outer_radius_ff;
         steep1_ff <= req_data.obstacle_distance <= inner_radius_ff;
         brg1_ff   <= brg_in;
         head1_ff  <= req_data.heading;
      end
   end

   // stage 2: products
   logic               v2_ff, act2_ff, steep2_ff;
   logic signed [32:0] tgx2_ff, tgy2_ff;
   logic signed [33:0] p1_2_ff, p2_2_ff;
   logic [32:0]        bq2_ff;
   logic [33:0]        bx2_ff;
   logic [15:0]        head2_ff;
   logic signed [16:0] gain_s, os_s, is_s;

   assign gain_s = signed'({1'b0, track_gain_ff});
   assign os_s   = signed'({1'b0, outer_slope_ff});
   assign is_s   = signed'({1'b0, inner_slope_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff     <= v1_ff;
         act2_ff   <= act1_ff;
         steep2_ff <= steep1_ff;
         tgx2_ff   <= 33'(gain_s) * 33'(ex1_ff);
         tgy2_ff   <= 33'(gain_s) * 33'(ey1_ff);
         p1_2_ff   <= 34'(os_s) * 34'(steep1_ff ? ro_ri1_ff : ro_d1_ff);
         p2_2_ff   <= 34'(is_s) * 34'(ri_d1_ff);
         bq2_ff    <= 33'(brg1_ff) * 33'(BRG_STEP);
         bx2_ff    <= 34'({brg1_ff, 8'd0} + BRG_HALF) * 34'(BRG_RECIP);
         head2_ff  <= head1_ff;
      end
   end

   // stage 3: rounded tracking clip, repulsion magnitude, bearing angle
   logic               v3_ff, act3_ff;
   logic signed [15:0] tx3_ff, ty3_ff;
   logic signed [CORDIC_IN_W-1:0] fx3_ff;
   logic [31:0]        ang3_ff;
   logic [15:0]        head3_ff;
   logic signed [33:0] tgx_r, tgy_r;
   logic signed [34:0] f_in;

   assign tgx_r = (34'(tgx2_ff) + 34'sd128) >>> 8;
   assign tgy_r = (34'(tgy2_ff) + 34'sd128) >>> 8;
   assign f_in  = steep2_ff ? (35'(p1_2_ff) + 35'(p2_2_ff)) : 35'(p1_2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff    <= v2_ff;
         act3_ff  <= act2_ff;
         tx3_ff   <= clip_limit(40'(tgx_r), track_limit_ff);
         ty3_ff   <= clip_limit(40'(tgy_r), track_limit_ff);
         // inactive avoidance rotates a null vector
         fx3_ff   <= act2_ff ? -CORDIC_IN_W'(f_in) : '0;
         ang3_ff  <= bq2_ff[31:0] + 32'(bx2_ff[33:BRG_RSHIFT]);
         head3_ff <= head2_ff;
      end
   end

   logic c1_valid;
   logic signed [CORDIC_OUT_W-1:0] c1_x, c1_y;

   pfvc_cordic u_repel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_x      (fx3_ff),
      .in_y      ('0),
      .in_angle  (ang3_ff),
      .out_valid (c1_valid),
      .out_x     (c1_x),
      .out_y     (c1_y)
   );

   typedef struct packed {
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic               act;
      logic [15:0]        head;
   } side_type;

   side_type side1_ff [CORDIC_LATENCY];
   logic     act2d_ff [CORDIC_LATENCY];

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff[0] <= '{tx: tx3_ff, ty: ty3_ff, act: act3_ff, head: head3_ff};
         for (int k = 1; k < CORDIC_LATENCY; k++) begin
            side1_ff[k] <= side1_ff[k-1];
         end
      end
   end

   // stage 4: repulsion round and clip
   logic               v4_ff, act4_ff;
   logic signed [15:0] rx4_ff, ry4_ff, tx4_ff, ty4_ff;
   logic [15:0]        head4_ff;
   logic signed [CORDIC_OUT_W-1:0] rx_r, ry_r;

   assign rx_r = (c1_x + CORDIC_OUT_W'(128)) >>> 8;
   assign ry_r = (c1_y + CORDIC_OUT_W'(128)) >>> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff    <= c1_valid;
         act4_ff  <= side1_ff[CORDIC_LATENCY-1].act;
         tx4_ff   <= side1_ff[CORDIC_LATENCY-1].tx;
         ty4_ff   <= side1_ff[CORDIC_LATENCY-1].ty;
         head4_ff <= side1_ff[CORDIC_LATENCY-1].head;
         rx4_ff   <= clip_limit(40'(rx_r), repel_limit_ff);
         ry4_ff   <= clip_limit(40'(ry_r), repel_limit_ff);
      end
   end

   // stage 5: summed command clip
   logic               v5_ff, act5_ff;
   logic signed [15:0] sx5_ff, sy5_ff;
   logic [31:0]        head5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff    <= v4_ff;
         act5_ff  <= act4_ff;
         sx5_ff   <= clip_limit(40'(tx4_ff) + 40'(rx4_ff), command_limit_ff);
         sy5_ff   <= clip_limit(40'(ty4_ff) + 40'(ry4_ff), command_limit_ff);
         head5_ff <= {head4_ff, 16'd0};
      end
   end

   logic c2_valid;
   logic signed [CORDIC_OUT_W-1:0] c2_x, c2_y;

   pfvc_cordic u_heading (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_x      (CORDIC_IN_W'(sx5_ff)),
      .in_y      (CORDIC_IN_W'(sy5_ff)),
      .in_angle  (head5_ff),
      .out_valid (c2_valid),
      .out_x     (c2_x),
      .out_y     (c2_y)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         act2d_ff[0] <= act5_ff;
         for (int k = 1; k < CORDIC_LATENCY; k++) begin
            act2d_ff[k] <= act2d_ff[k-1];
         end
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff             <= c2_valid;
         rsp_data_ff.vel_east     <= sat16(40'(c2_x));
         rsp_data_ff.vel_north    <= sat16(40'(c2_y));
         rsp_data_ff.avoid_active <= act2d_ff[CORDIC_LATENCY-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pfvc_checker.sv
// ----------------------------------------------------------------------------
// pfvc_checker
// Port-level checks of the velocity command block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvc_checker
   import pfvc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // output valid drops on reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side stalls exactly when a response transaction is blocked
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall not tied to blocked response");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

endmodule

bind potential_field_velocity_command pfvc_checker u_pfvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
